// ===== rtl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner package
// Shared widths, codes, register layout and the move planning function.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int POSITION_BITS = 13;
  localparam int SMALL_BITS    = 3;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [SMALL_BITS-1:0]    small_t;
  typedef logic [1:0]               stat_t;
  typedef logic [1:0]               reg_idx_t;

  localparam pos_t   TOTAL_STEPS_RST       = POSITION_BITS'(5930);
  localparam pos_t   REVERSE_THRESHOLD_RST = POSITION_BITS'(4000);
  localparam small_t CENTER_DELAY_RST      = SMALL_BITS'(5);
  localparam small_t HOME_EXTRA_STEPS_RST  = SMALL_BITS'(3);

  localparam reg_idx_t REG_TOTAL_STEPS       = 2'd0;
  localparam reg_idx_t REG_REVERSE_THRESHOLD = 2'd1;
  localparam reg_idx_t REG_CENTER_DELAY      = 2'd2;
  localparam reg_idx_t REG_HOME_EXTRA_STEPS  = 2'd3;

  localparam logic REQ_TARGET = 1'b0;
  localparam logic DIR_RIGHT  = 1'b0;
  localparam logic DIR_LEFT   = 1'b1;

  localparam stat_t STAT_IDLE       = 2'd0;
  localparam stat_t STAT_MOVING     = 2'd1;
  localparam stat_t STAT_HOMING     = 2'd2;
  localparam stat_t STAT_RECENTERED = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_BACKOFF = 5'b00010,
    PH_SEEK    = 5'b00100,
    PH_EXTRA   = 5'b01000,
    PH_MOVE    = 5'b10000
  } phase_t;

  typedef struct packed {
    pos_t   total_steps;
    pos_t   reverse_threshold;
    small_t center_delay;
    small_t home_extra_steps;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    pos_t target_pos;
    logic hall_a;
    logic hall_b;
  } item_t;

  typedef struct packed {
    logic  step_valid;
    logic  step_dir;
    logic  busy_res;
    pos_t  position;
    stat_t status;
  } result_t;

  typedef struct packed {
    phase_t phase;
    pos_t   position;
    pos_t   steps;
    logic   left;
  } plan_t;

  // Plans a move from pos to tgt; steps and left are kept when no move results.
  function automatic plan_t plan_move(pos_t tgt, pos_t pos, pos_t steps, logic left,
                                      cfg_t cfg);
    plan_t p;
    pos_t  off;
    pos_t  cnt;
    logic  dir;
    off = tgt - pos;
    if (tgt < pos) begin
      dir = DIR_LEFT;
      cnt = pos - tgt;
    end else if (off > cfg.reverse_threshold) begin
      dir = DIR_LEFT;
      cnt = (cfg.total_steps > off) ? (cfg.total_steps - off) : '0;
    end else begin
      dir = DIR_RIGHT;
      cnt = off;
    end
    if (cnt == '0) begin
      p.phase    = PH_IDLE;
      p.position = tgt;
      p.steps    = steps;
      p.left     = left;
    end else begin
      p.phase    = PH_MOVE;
      p.position = pos;
      p.steps    = cnt;
      p.left     = dir;
    end
    return p;
  endfunction

endpackage

// ===== rtl/sdp_if.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner channels
// Valid/ready channels for command and tick words and for step result words.
// ----------------------------------------------------------------------------
interface sdp_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  sdp_pkg::pos_t      target_pos;
  logic               hall_a;
  logic               hall_b;

  modport source (output valid, req_type, target_pos, hall_a, hall_b, input ready);
  modport sink   (input valid, req_type, target_pos, hall_a, hall_b, output ready);
endinterface

interface sdp_out_if;
  logic               valid;
  logic               ready;
  logic               step_valid;
  logic               step_dir;
  logic               busy_res;
  sdp_pkg::pos_t      position;
  sdp_pkg::stat_t     status;

  modport source (output valid, step_valid, step_dir, busy_res, position, status,
                  input ready);
  modport sink   (input valid, step_valid, step_dir, busy_res, position, status,
                  output ready);
endinterface

// ===== rtl/stepper_dial_positioner.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner
// Steps a clock dial toward commanded positions, with homing and recentring.
//
//   Port group   Direction   Carries
//   in_ch        sink        command or tick word (type, target, hall levels)
//   out_ch       source      one step result word per input word
//   APB          slave       four configuration registers at 0x0 to 0xC
//
// Each word is held in an input register, decided in one pass against the
// dial state, and lands in the output register once it is free or drained.
// One word is accepted per cycle while the output register is free or drained.
// A stalled output holds the input register, which then holds in_ch.ready low.
// After reset the dial starts in the homing back-off phase.
// ----------------------------------------------------------------------------
module stepper_dial_positioner (
  input  logic                           clk,
  input  logic                           rst_n,
  sdp_in_if.sink                         in_ch,
  sdp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [sdp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [sdp_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  sdp_pkg::cfg_t    cfg;
  sdp_pkg::item_t   inq_r;
  logic             inq_vld_r;
  sdp_pkg::result_t res;
  sdp_pkg::result_t res_r;
  logic             out_vld_r;
  logic             in_fire;
  logic             adv;

  assign adv          = inq_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready  = ~inq_vld_r | adv;
  assign in_fire      = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      inq_vld_r <= in_fire | (inq_vld_r & ~adv);
      out_vld_r <= adv | (out_vld_r & ~out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_r.req_type   <= in_ch.req_type;
      inq_r.target_pos <= in_ch.target_pos;
      inq_r.hall_a     <= in_ch.hall_a;
      inq_r.hall_b     <= in_ch.hall_b;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  sdp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdp_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (inq_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid      = out_vld_r;
  assign out_ch.step_valid = res_r.step_valid;
  assign out_ch.step_dir   = res_r.step_dir;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.position   = res_r.position;
  assign out_ch.status     = res_r.status;

endmodule

// ===== rtl/sdp_regs.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner configuration registers
// APB register file holding the revolution, threshold and homing settings.
// ----------------------------------------------------------------------------
module sdp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [sdp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [sdp_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output sdp_pkg::cfg_t                  cfg
);

  sdp_pkg::cfg_t     cfg_r;
  sdp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_steps       <= sdp_pkg::TOTAL_STEPS_RST;
      cfg_r.reverse_threshold <= sdp_pkg::REVERSE_THRESHOLD_RST;
      cfg_r.center_delay      <= sdp_pkg::CENTER_DELAY_RST;
      cfg_r.home_extra_steps  <= sdp_pkg::HOME_EXTRA_STEPS_RST;
    end else if (wr_en) begin
      unique case (idx)
        sdp_pkg::REG_TOTAL_STEPS: begin
          cfg_r.total_steps <= pwdata[sdp_pkg::POSITION_BITS-1:0];
        end
        sdp_pkg::REG_REVERSE_THRESHOLD: begin
          cfg_r.reverse_threshold <= pwdata[sdp_pkg::POSITION_BITS-1:0];
        end
        sdp_pkg::REG_CENTER_DELAY: begin
          cfg_r.center_delay <= pwdata[sdp_pkg::SMALL_BITS-1:0];
        end
        sdp_pkg::REG_HOME_EXTRA_STEPS: begin
          cfg_r.home_extra_steps <= pwdata[sdp_pkg::SMALL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sdp_pkg::REG_TOTAL_STEPS:       prdata = sdp_pkg::DATA_BITS'(cfg_r.total_steps);
      sdp_pkg::REG_REVERSE_THRESHOLD: prdata = sdp_pkg::DATA_BITS'(cfg_r.reverse_threshold);
      sdp_pkg::REG_CENTER_DELAY:      prdata = sdp_pkg::DATA_BITS'(cfg_r.center_delay);
      sdp_pkg::REG_HOME_EXTRA_STEPS:  prdata = sdp_pkg::DATA_BITS'(cfg_r.home_extra_steps);
      default:                        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sdp_engine.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner engine
// Dial state and the single-pass step decision for one registered word.
// ----------------------------------------------------------------------------
module sdp_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  sdp_pkg::item_t   item,
  input  sdp_pkg::cfg_t    cfg,
  output sdp_pkg::result_t res
);

  sdp_pkg::phase_t phase_r, phase_nxt;
  sdp_pkg::pos_t   pos_r, pos_nxt;
  sdp_pkg::pos_t   prev_r, prev_nxt;
  sdp_pkg::pos_t   steps_r, steps_nxt;
  logic            left_r, left_nxt;
  logic            day_r, day_nxt;
  sdp_pkg::small_t cd_r, cd_nxt;

  sdp_pkg::plan_t  plan;
  sdp_pkg::small_t cd;
  logic            a0;
  logic            on24;
  logic            step;
  logic            dir;
  logic            recentered;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    left_nxt   = left_r;
    day_nxt    = day_r;
    cd_nxt     = cd_r;
    step       = 1'b0;
    dir        = sdp_pkg::DIR_RIGHT;
    recentered = 1'b0;
    plan       = '0;
    cd         = cd_r;
    a0         = ~item.hall_a;
    on24       = a0 & ~item.hall_b;

    if (item.req_type == sdp_pkg::REQ_TARGET) begin
      if (phase_r == sdp_pkg::PH_IDLE) begin
        prev_nxt = item.target_pos;
        if (prev_r > item.target_pos) begin
          phase_nxt = sdp_pkg::PH_BACKOFF;
        end else begin
          plan      = sdp_pkg::plan_move(item.target_pos, pos_r, steps_r, left_r, cfg);
          phase_nxt = plan.phase;
          pos_nxt   = plan.position;
          steps_nxt = plan.steps;
          left_nxt  = plan.left;
        end
      end
    end else begin
      unique case (phase_r)
        sdp_pkg::PH_BACKOFF: begin
          step = 1'b1;
          if (on24) begin
            dir = sdp_pkg::DIR_LEFT;
          end else begin
            phase_nxt = sdp_pkg::PH_SEEK;
          end
        end
        sdp_pkg::PH_SEEK: begin
          if (!on24) begin
            step = 1'b1;
          end else begin
            pos_nxt   = '0;
            day_nxt   = 1'b0;
            steps_nxt = sdp_pkg::POSITION_BITS'(cfg.home_extra_steps);
            phase_nxt = sdp_pkg::PH_EXTRA;
            if (cfg.home_extra_steps != '0) begin
              step      = 1'b1;
              steps_nxt = sdp_pkg::POSITION_BITS'(cfg.home_extra_steps - 1'b1);
            end
            if (steps_nxt == '0) begin
              plan      = sdp_pkg::plan_move(prev_r, '0, steps_nxt, left_r, cfg);
              phase_nxt = plan.phase;
              pos_nxt   = plan.position;
              steps_nxt = plan.steps;
              left_nxt  = plan.left;
            end
          end
        end
        sdp_pkg::PH_EXTRA: begin
          if (steps_r != '0) begin
            step      = 1'b1;
            steps_nxt = steps_r - 1'b1;
          end
          if (steps_nxt == '0) begin
            plan      = sdp_pkg::plan_move(prev_r, pos_r, steps_nxt, left_r, cfg);
            phase_nxt = plan.phase;
            pos_nxt   = plan.position;
            steps_nxt = plan.steps;
            left_nxt  = plan.left;
          end
        end
        sdp_pkg::PH_MOVE: begin
          step = 1'b1;
          dir  = left_r;
          if (left_r == sdp_pkg::DIR_RIGHT) begin
            if (!day_r && on24) begin
              cd = cfg.center_delay;
            end
            cd_nxt = cd;
            if (cd != '0) begin
              cd_nxt = cd - 1'b1;
              if (cd == sdp_pkg::SMALL_BITS'(1)) begin
                recentered = 1'b1;
              end
            end
          end
          if (recentered) begin
            plan      = sdp_pkg::plan_move(prev_r, '0, steps_r, left_r, cfg);
            phase_nxt = plan.phase;
            pos_nxt   = plan.position;
            steps_nxt = plan.steps;
            left_nxt  = plan.left;
          end else begin
            day_nxt   = on24;
            steps_nxt = steps_r - 1'b1;
            if (steps_nxt == '0) begin
              pos_nxt   = prev_r;
              phase_nxt = sdp_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = sdp_pkg::PH_IDLE;
        end
      endcase
    end

    res.step_valid = step;
    res.step_dir   = step & dir;
    res.busy_res   = (phase_nxt != sdp_pkg::PH_IDLE);
    res.position   = pos_nxt;
    if (recentered) begin
      res.status = sdp_pkg::STAT_RECENTERED;
    end else if (phase_nxt == sdp_pkg::PH_IDLE) begin
      res.status = sdp_pkg::STAT_IDLE;
    end else if (phase_nxt == sdp_pkg::PH_MOVE) begin
      res.status = sdp_pkg::STAT_MOVING;
    end else begin
      res.status = sdp_pkg::STAT_HOMING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdp_pkg::PH_BACKOFF;
      pos_r   <= '0;
      prev_r  <= '0;
      steps_r <= '0;
      left_r  <= 1'b0;
      day_r   <= 1'b0;
      cd_r    <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      steps_r <= steps_nxt;
      left_r  <= left_nxt;
      day_r   <= day_nxt;
      cd_r    <= cd_nxt;
    end
  end

endmodule

// ===== rtl/sdp_checker.sv =====
// ----------------------------------------------------------------------------
// Stepper dial positioner checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sdp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input logic           step_valid,
  input logic           step_dir,
  input logic           busy_res,
  input sdp_pkg::pos_t  position,
  input sdp_pkg::stat_t status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(status))
    else $error("Result word changed while stalled.");

  a_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == sdp_pkg::STAT_IDLE) |-> !busy_res)
    else $error("Idle status reported while busy.");

  a_busy_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy_res |-> (status != sdp_pkg::STAT_IDLE))
    else $error("Busy reported with idle status.");

  a_dir_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_dir |-> step_valid)
    else $error("Left direction shown without a step.");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("Result word valid straight after reset.");

endmodule

bind stepper_dial_positioner sdp_checker u_sdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .step_valid (out_ch.step_valid),
  .step_dir   (out_ch.step_dir),
  .busy_res   (out_ch.busy_res),
  .position   (out_ch.position),
  .status     (out_ch.status)
);

// ===== test/stepper_dial_positioner_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper dial positioner checker
// Watches the command/tick channel, the step result channel and the register
// port, keeps its own copy of the dial state and settings, works out the step
// word due for every accepted input word and compares each accepted result
// word against the oldest one still due, field by field.
// ----------------------------------------------------------------------------
module stepper_dial_positioner_check (
  input  logic                          clk,
  input  logic                          rst_n,
  sdp_in_if                             in_mon,
  sdp_out_if                            out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sdp_pkg::DATA_BITS-1:0] pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);
  import sdp_pkg::*;

  phase_t     ph;
  pos_t       dial_pos;
  pos_t       dial_target;
  pos_t       steps_due;
  logic       going_left;
  logic       day_mark;
  logic [3:0] centre_count;
  pos_t       total_steps;
  pos_t       reverse_thr;
  small_t     centre_delay;
  small_t     extra_steps;
  result_t    step_words_due [$];

  function automatic void plan_to_target();
    int   off;
    int   cnt;
    logic lft;
    off = int'(dial_target) - int'(dial_pos);
    if (off < 0) begin
      lft = DIR_LEFT;
      cnt = -off;
    end else if (off > int'(reverse_thr)) begin
      lft = DIR_LEFT;
      cnt = (int'(total_steps) > off) ? int'(total_steps) - off : 0;
    end else begin
      lft = DIR_RIGHT;
      cnt = off;
    end
    if (cnt == 0) begin
      dial_pos = dial_target;
      ph       = PH_IDLE;
    end else begin
      steps_due  = pos_t'(cnt);
      going_left = lft;
      ph         = PH_MOVE;
    end
  endfunction

  function automatic logic take_extra_step();
    logic stepped;
    stepped = 1'b0;
    if (steps_due != '0) begin
      stepped   = 1'b1;
      steps_due = steps_due - 1'b1;
    end
    if (steps_due == '0) plan_to_target();
    return stepped;
  endfunction

  function automatic result_t next_step_word(item_t w);
    result_t    r;
    logic       stp;
    logic       dr;
    logic       recentred;
    logic       a0;
    logic       on24;
    logic [3:0] old;
    stp       = 1'b0;
    dr        = DIR_RIGHT;
    recentred = 1'b0;
    if (w.req_type == REQ_TARGET) begin
      if (ph == PH_IDLE) begin
        if (dial_target > w.target_pos) begin
          dial_target = w.target_pos;
          ph          = PH_BACKOFF;
        end else begin
          dial_target = w.target_pos;
          plan_to_target();
        end
      end
    end else begin
      a0   = !w.hall_a;
      on24 = a0 && !w.hall_b;
      case (ph)
        PH_BACKOFF: begin
          stp = 1'b1;
          if (on24) begin
            dr = DIR_LEFT;
          end else begin
            ph = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (!on24) begin
            stp = 1'b1;
          end else begin
            dial_pos  = '0;
            day_mark  = 1'b0;
            steps_due = pos_t'(extra_steps);
            ph        = PH_EXTRA;
            stp       = take_extra_step();
          end
        end
        PH_EXTRA: begin
          stp = take_extra_step();
        end
        PH_MOVE: begin
          stp = 1'b1;
          dr  = going_left;
          if (dr == DIR_RIGHT) begin
            if (!day_mark && on24) centre_count = 4'(centre_delay);
            if (centre_count != '0) begin
              old          = centre_count;
              centre_count = old - 1'b1;
              if (old == 4'd1) begin
                dial_pos  = '0;
                recentred = 1'b1;
                plan_to_target();
              end
            end
          end
          if (!recentred) begin
            day_mark  = on24;
            steps_due = steps_due - 1'b1;
            if (steps_due == '0) begin
              dial_pos = dial_target;
              ph       = PH_IDLE;
            end
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase
    end
    r.step_valid = stp;
    r.step_dir   = stp ? dr : DIR_RIGHT;
    r.busy_res   = (ph != PH_IDLE);
    r.position   = dial_pos;
    if (recentred)           r.status = STAT_RECENTERED;
    else if (ph == PH_IDLE)  r.status = STAT_IDLE;
    else if (ph == PH_MOVE)  r.status = STAT_MOVING;
    else                     r.status = STAT_HOMING;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    if (!rst_n) begin
      total_steps  = TOTAL_STEPS_RST;
      reverse_thr  = REVERSE_THRESHOLD_RST;
      centre_delay = CENTER_DELAY_RST;
      extra_steps  = HOME_EXTRA_STEPS_RST;
      ph           = PH_BACKOFF;
      dial_pos     = '0;
      dial_target  = '0;
      steps_due    = '0;
      going_left   = 1'b0;
      day_mark     = 1'b0;
      centre_count = '0;
      step_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
          REG_TOTAL_STEPS:       total_steps  = pwdata[POSITION_BITS-1:0];
          REG_REVERSE_THRESHOLD: reverse_thr  = pwdata[POSITION_BITS-1:0];
          REG_CENTER_DELAY:      centre_delay = pwdata[SMALL_BITS-1:0];
          REG_HOME_EXTRA_STEPS:  extra_steps  = pwdata[SMALL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        w.req_type   = in_mon.req_type;
        w.target_pos = in_mon.target_pos;
        w.hall_a     = in_mon.hall_a;
        w.hall_b     = in_mon.hall_b;
        step_words_due.push_back(next_step_word(w));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (step_words_due.size() == 0) begin
          errors++;
          $display("%0t: step word with none due, expected nothing, actual %h", $time,
                   {out_mon.step_valid, out_mon.step_dir, out_mon.busy_res,
                    out_mon.position, out_mon.status});
        end else begin
          want = step_words_due.pop_front();
          check_field("step_valid", want.step_valid, out_mon.step_valid);
          check_field("step_dir", want.step_dir, out_mon.step_dir);
          check_field("busy_res", want.busy_res, out_mon.busy_res);
          check_field("position", want.position, out_mon.position);
          check_field("status", want.status, out_mon.status);
        end
      end
    end
    pending <= step_words_due.size();
  end

endmodule

// ===== test/stepper_dial_positioner_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper dial positioner test
// Drives target commands and sensor ticks into the positioner, writes its
// settings between phases over the register port, and throttles both sides
// of the word channels at random. A directed opening walks through homing,
// jumps, ignored commands and recentring; random phases follow under several
// settings, the extremes among them. The checker beside the block predicts
// and compares every step word and the verdict is given here.
// ----------------------------------------------------------------------------
module stepper_dial_positioner_test;
  import sdp_pkg::*;

  localparam int LONG_HOLD = 50;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 calm = 1'b0;
  int                   hold_requests = 0;
  int                   errors;
  int                   pending;
  pos_t                 cur_total = TOTAL_STEPS_RST;
  pos_t                 cur_thr = REVERSE_THRESHOLD_RST;

  sdp_in_if  in_ch ();
  sdp_out_if out_ch ();

  stepper_dial_positioner i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stepper_dial_positioner_check i_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  initial begin : watchdog
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : result_sink
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seen != hold_requests) begin
        seen = hold_requests;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input item_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= w.req_type;
    in_ch.target_pos <= w.target_pos;
    in_ch.hall_a     <= w.hall_a;
    in_ch.hall_b     <= w.hall_b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_cmd(input pos_t target);
    item_t w;
    w.req_type   = REQ_TARGET;
    w.target_pos = target;
    w.hall_a     = 1'($urandom);
    w.hall_b     = 1'($urandom);
    send_word(w);
  endtask

  task automatic send_tick(input logic a, input logic b);
    item_t w;
    w.req_type   = !REQ_TARGET;
    w.target_pos = pos_t'($urandom_range(0, 8191));
    w.hall_a     = a;
    w.hall_b     = b;
    send_word(w);
  endtask

  // The 24h mark turns up often enough for homing and recentring to finish.
  task automatic send_random_tick();
    case ($urandom_range(0, 7))
      0:       send_tick(1'b0, 1'b0);
      1:       send_tick(1'b0, 1'b1);
      2:       send_tick(1'b1, 1'b0);
      default: send_tick(1'b1, 1'b1);
    endcase
  endtask

  // Far targets are only offered where they resolve into a jump or a short move.
  function automatic pos_t pick_target();
    if (cur_thr < 64 && cur_total < 128 && $urandom_range(0, 3) == 0)
      return pos_t'($urandom_range(0, 8191));
    return pos_t'($urandom_range(0, 63));
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(input pos_t total, input pos_t thr, input small_t delay,
                            input small_t extra);
    logic [DATA_BITS-1:0] vals [4];
    vals[REG_TOTAL_STEPS]       = DATA_BITS'(total);
    vals[REG_REVERSE_THRESHOLD] = DATA_BITS'(thr);
    vals[REG_CENTER_DELAY]      = DATA_BITS'(delay);
    vals[REG_HOME_EXTRA_STEPS]  = DATA_BITS'(extra);
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'(i) << 2;
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_total = total;
    cur_thr   = thr;
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int ticks;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        send_cmd(pick_target());
        ticks = $urandom_range(2, 40);
        repeat (ticks) send_random_tick();
        sent += ticks + 1;
      end else begin
        repeat (3) begin
          if ($urandom_range(0, 1) == 1) send_cmd(pick_target());
          else send_random_tick();
        end
        sent += 3;
      end
    end
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_TARGET;
    in_ch.target_pos = '0;
    in_ch.hall_a     = 1'b1;
    in_ch.hall_b     = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Homing from reset: a command is ignored, back off the mark, seek it again.
    send_cmd(pos_t'(8191));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    // A far target jumps at once, the same target again does nothing, a lower one homes.
    send_cmd(pos_t'(8191));
    send_cmd(pos_t'(8191));
    send_cmd(pos_t'(0));
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    // A right move that passes the 24h mark and is recentred.
    send_cmd(pos_t'(12));
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b1);
    send_cmd(pos_t'(0));
    drain();

    set_config(pos_t'(8191), pos_t'(8191), small_t'(7), small_t'(7));
    run_phase(150);
    drain();
    set_config(pos_t'(2), pos_t'(0), small_t'(1), small_t'(0));
    run_phase(120);
    drain();
    set_config(pos_t'(60), pos_t'(20), small_t'(0), small_t'(5));
    run_phase(120);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_config(pos_t'($urandom_range(2, 100)), pos_t'($urandom_range(0, 80)),
                 small_t'($urandom_range(0, 7)), small_t'($urandom_range(0, 7)));
      if (k == 0) hold_requests++;
      run_phase(120);
      drain();
    end
    calm = 1'b1;
    set_config(TOTAL_STEPS_RST, REVERSE_THRESHOLD_RST, CENTER_DELAY_RST,
               HOME_EXTRA_STEPS_RST);
    run_phase(120);
    drain();
    repeat (4) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
